// ===== src/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants for the sorted priority queue
// Queue geometry, entry layout, status codes, controller states and the
// command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W      = 8;
  localparam int ID_W        = 16;
  localparam int TAG_W       = 16;
  localparam int OCC_W       = 5;
  localparam int STAT_W      = 2;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POPPED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== src/ssq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssq_ctrl: sequencer for the sorted priority queue
// Takes a command, drives the datapath through its execute state and raises the
// result strobe in the cycle after it.
// ----------------------------------------------------------------------------
module ssq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output ssq_pkg::cmd_t     cmd
);

  ssq_pkg::state_t state;
  ssq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssq_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.execute;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssq_pkg::S_IDLE: begin
        if (start) state_next = ssq_pkg::S_EXEC;
      end
      ssq_pkg::S_EXEC: begin
        state_next = ssq_pkg::S_IDLE;
      end
      default: state_next = ssq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ssq_pkg::S_IDLE: begin
        cmd.capture = start;
      end
      ssq_pkg::S_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // a result strobe always rises in the cycle after an execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> done)
    else $error("result strobe missing after execute");

  // never take a new item while executing
  a_no_capture_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.capture)
    else $error("capture while busy");

  // execute only right after a capture
  a_exec_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> $past(cmd.capture))
    else $error("execute without capture");

endmodule

// ===== src/ssq_dp.sv =====
// ----------------------------------------------------------------------------
// ssq_dp: sorted entry row and result registers
// A row of entry cells kept in descending priority order. Each cell compares
// its priority with the request in parallel and picks hold, shift or load.
// ----------------------------------------------------------------------------
module ssq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ssq_pkg::cmd_t                cmd,
  input  logic                         mode,
  input  logic [ssq_pkg::PRIO_W-1:0]   priority_req,
  input  logic [ssq_pkg::TAG_W-1:0]    tag,
  output logic [ssq_pkg::STAT_W-1:0]   status,
  output logic [ssq_pkg::ID_W-1:0]     out_id,
  output logic [ssq_pkg::PRIO_W-1:0]   out_priority,
  output logic [ssq_pkg::TAG_W-1:0]    out_tag,
  output logic [ssq_pkg::OCC_W-1:0]    occupancy
);

  localparam int D = ssq_pkg::QUEUE_DEPTH;

  logic                         mode_q;
  logic [ssq_pkg::PRIO_W-1:0]   prio_q;
  logic [ssq_pkg::TAG_W-1:0]    tag_q;

  ssq_pkg::entry_t              entries      [D];
  ssq_pkg::entry_t              ins_next     [D];
  ssq_pkg::entry_t              pop_next     [D];
  ssq_pkg::entry_t              new_entry;
  logic [D-1:0]                 ge;

  logic [ssq_pkg::CNT_W-1:0]    count;
  logic [ssq_pkg::ID_W-1:0]     next_id;
  logic                         full;
  logic                         empty;

  assign full  = (count == ssq_pkg::CNT_W'(D));
  assign empty = (count == '0);

  assign new_entry.prio = prio_q;
  assign new_entry.id   = next_id;
  assign new_entry.tag  = tag_q;

  // per-cell compare: occupied and at least as urgent as the request
  always_comb begin
    for (int i = 0; i < D; i++) begin
      ge[i] = (ssq_pkg::CNT_W'(i) < count) && (entries[i].prio >= prio_q);
    end
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign ins_next[g] = ge[g] ? entries[g] : new_entry;
    end else begin : g_body
      assign ins_next[g] = ge[g]     ? entries[g]   :
                           ge[g - 1] ? new_entry    : entries[g - 1];
    end
    if (g == D - 1) begin : g_tail
      assign pop_next[g] = entries[g];
    end else begin : g_inner
      assign pop_next[g] = entries[g + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      prio_q <= priority_req;
      tag_q  <= tag;
    end
    if (cmd.execute) begin
      priority if (mode_q == ssq_pkg::MODE_INSERT && !full) begin
        entries      <= ins_next;
        status       <= ssq_pkg::STAT_INSERTED;
        out_id       <= next_id;
        out_priority <= '0;
        out_tag      <= '0;
      end else if (mode_q == ssq_pkg::MODE_INSERT) begin
        status       <= ssq_pkg::STAT_FULL;
        out_id       <= '0;
        out_priority <= '0;
        out_tag      <= '0;
      end else if (!empty) begin
        entries      <= pop_next;
        status       <= ssq_pkg::STAT_POPPED;
        out_id       <= entries[0].id;
        out_priority <= entries[0].prio;
        out_tag      <= entries[0].tag;
      end else begin
        status       <= ssq_pkg::STAT_EMPTY;
        out_id       <= '0;
        out_priority <= '0;
        out_tag      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= ssq_pkg::ID_W'(1);
    end else if (cmd.execute) begin
      if (mode_q == ssq_pkg::MODE_INSERT && !full) begin
        count   <= count + 1'b1;
        next_id <= next_id + 1'b1;
      end else if (mode_q == ssq_pkg::MODE_POP && !empty) begin
        count   <= count - 1'b1;
      end
    end
  end

  assign occupancy = ssq_pkg::OCC_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ssq_pkg::CNT_W'(D))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && mode_q == ssq_pkg::MODE_INSERT && !full |=>
      count == $past(count) + 1'b1 && status == ssq_pkg::STAT_INSERTED)
    else $error("insert did not add an entry");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && mode_q == ssq_pkg::MODE_POP && empty |=>
      count == '0 && status == ssq_pkg::STAT_EMPTY)
    else $error("pop on empty changed state");

endmodule

// ===== src/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded priority queue, FIFO among equals
// Insert and pop commands on a queue kept sorted by priority, highest first.
// ----------------------------------------------------------------------------
// Usage: drive mode, priority_req and tag and raise start; the item is taken
// at a clock edge where start is high and busy is low. Each item is first
// captured, then the entry row compares and shifts all cells at once. The
// result appears for exactly one cycle, marked by done, in the cycle after
// the execute cycle; busy is already low then, so the next item can be
// taken in that same cycle. The receiver cannot stall: sample the result
// ports whenever done is high. Inserts get ids from a 16-bit counter that
// starts at 1 and wraps through 0; an insert into a full queue is dropped
// with status 3 and does not consume an id. A pop on an empty queue
// returns status 2. occupancy is the entry count after the item and stays
// valid between results.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [ssq_pkg::PRIO_W-1:0]   priority_req,
  input  logic [ssq_pkg::TAG_W-1:0]    tag,
  output logic                         done,
  output logic [ssq_pkg::STAT_W-1:0]   status,
  output logic [ssq_pkg::ID_W-1:0]     out_id,
  output logic [ssq_pkg::PRIO_W-1:0]   out_priority,
  output logic [ssq_pkg::TAG_W-1:0]    out_tag,
  output logic [ssq_pkg::OCC_W-1:0]    occupancy
);

  // commands from the sequencer to the entry row
  ssq_pkg::cmd_t cmd;

  // sequencer: capture, execute, strobe the result
  ssq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // entry row, id counter and result registers
  ssq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .priority_req (priority_req),
    .tag          (tag),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .occupancy    (occupancy)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_sorted_priority_queue
// Drives insert and pop items through the start/busy handshake, predicts
// every result with a shadow copy of the sorted queue, and compares each
// done strobe field by field against the oldest prediction. Covers pop on
// empty, fill to full, drop on full, ties kept in arrival order, insert/pop
// pairs back to back, and a long run of random traffic with sender gaps.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles with no item taken and no result seen before the run is called hung.
  localparam int WATCHDOG_LIMIT = 200;
  // Cycles to keep watching for stray results once nothing is outstanding.
  localparam int TAIL_CYCLES    = 8;
  localparam int PAIR_COUNT     = 12;
  localparam int RANDOM_ITEMS   = 560;
  localparam int QUIET_ITEMS    = 100;

  typedef struct packed {
    logic [ssq_pkg::STAT_W-1:0] status;
    logic [ssq_pkg::ID_W-1:0]   id;
    logic [ssq_pkg::PRIO_W-1:0] prio;
    logic [ssq_pkg::TAG_W-1:0]  tag;
    logic [ssq_pkg::OCC_W-1:0]  occ;
  } qresult_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       mode;
  logic [ssq_pkg::PRIO_W-1:0] priority_req;
  logic [ssq_pkg::TAG_W-1:0]  tag;
  logic                       done;
  logic [ssq_pkg::STAT_W-1:0] status;
  logic [ssq_pkg::ID_W-1:0]   out_id;
  logic [ssq_pkg::PRIO_W-1:0] out_priority;
  logic [ssq_pkg::TAG_W-1:0]  out_tag;
  logic [ssq_pkg::OCC_W-1:0]  occupancy;

  // Shadow queue: slot 0 is the head, only the first shadow_count slots are live.
  ssq_pkg::entry_t          shadow_slots [ssq_pkg::QUEUE_DEPTH];
  int                       shadow_count;
  logic [ssq_pkg::ID_W-1:0] shadow_id;

  qresult_t expected_results [$];
  int       error_count;
  int       stall_cycles;

  stable_sorted_priority_queue u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .priority_req (priority_req),
    .tag          (tag),
    .done         (done),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .out_tag      (out_tag),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one item to the shadow queue and return the result it must produce.
  function automatic qresult_t predict_queue_result(
      input logic m,
      input logic [ssq_pkg::PRIO_W-1:0] p,
      input logic [ssq_pkg::TAG_W-1:0] t);
    qresult_t r;
    int       pos;
    int       i;
    r = '0;
    if (m == ssq_pkg::MODE_INSERT) begin
      if (shadow_count >= ssq_pkg::QUEUE_DEPTH) begin
        // Drop the entry; the id counter holds.
        r.status = ssq_pkg::STAT_FULL;
      end else begin
        // Land after every entry of greater or equal priority, so ties stay FIFO.
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].prio >= p) pos++;
        for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].prio = p;
        shadow_slots[pos].id   = shadow_id;
        shadow_slots[pos].tag  = t;
        shadow_count++;
        r.status  = ssq_pkg::STAT_INSERTED;
        r.id      = shadow_id;
        shadow_id = shadow_id + 1'b1;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ssq_pkg::STAT_EMPTY;
      end else begin
        r.status = ssq_pkg::STAT_POPPED;
        r.id     = shadow_slots[0].id;
        r.prio   = shadow_slots[0].prio;
        r.tag    = shadow_slots[0].tag;
        for (i = 1; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
        shadow_count--;
      end
    end
    r.occ = ssq_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  // Favor the extremes and a narrow band of values so ties show up often.
  function automatic logic [ssq_pkg::PRIO_W-1:0] pick_priority();
    logic [ssq_pkg::PRIO_W-1:0] p;
    case ($urandom_range(0, 3))
      0: p = $urandom_range(0, 1) ? '1 : '0;
      1: p = ssq_pkg::PRIO_W'($urandom_range(8'h40, 8'h43));
      default: p = ssq_pkg::PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  // Present one item at the falling edge and hold it until an edge takes it.
  task automatic send_item(input logic m, input logic [ssq_pkg::PRIO_W-1:0] p,
                           input logic [ssq_pkg::TAG_W-1:0] t);
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    priority_req <= p;
    tag          <= t;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_queue_result(m, p, t));
  endtask

  // Hold start low for a number of cycles, scrambling the idle payload.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      mode         <= 1'($urandom);
      priority_req <= ssq_pkg::PRIO_W'($urandom);
      tag          <= ssq_pkg::TAG_W'($urandom);
    end
  endtask

  // Stop sending and wait for every outstanding result to come back.
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Pop on an empty queue right after reset.
  task automatic test_pop_on_empty();
    send_item(ssq_pkg::MODE_POP, '1, '1);
  endtask

  // Fill with extreme priorities and ties, then try one insert past full.
  task automatic test_fill_to_full();
    logic [ssq_pkg::PRIO_W-1:0] fill_prio [ssq_pkg::QUEUE_DEPTH];
    int                         i;
    fill_prio = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h80,
                  8'h00, 8'hFE, 8'h80, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h00};
    for (i = 0; i < ssq_pkg::QUEUE_DEPTH; i++)
      send_item(ssq_pkg::MODE_INSERT, fill_prio[i], ssq_pkg::TAG_W'(i * 16'h1111));
    send_item(ssq_pkg::MODE_INSERT, 8'hFF, 16'hFFFF);
  endtask

  // Take a few heads off; they must come out highest first, oldest first on ties.
  task automatic test_pop_order();
    repeat (5)
      send_item(ssq_pkg::MODE_POP, ssq_pkg::PRIO_W'($urandom),
                ssq_pkg::TAG_W'($urandom));
  endtask

  // Alternate inserts and pops back to back, on the entries left by the pop test.
  task automatic test_insert_pop_pairs();
    repeat (PAIR_COUNT) begin
      send_item(ssq_pkg::MODE_INSERT, pick_priority(), ssq_pkg::TAG_W'($urandom));
      send_item(ssq_pkg::MODE_POP, ssq_pkg::PRIO_W'($urandom),
                ssq_pkg::TAG_W'($urandom));
    end
  endtask

  // Random traffic in phases that lean toward full, toward empty, then balanced.
  task automatic test_random_traffic();
    int i;
    int insert_pct;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      insert_pct = (i < 200) ? 75 : (i < 400) ? 25 : 55;
      if (i < RANDOM_ITEMS - QUIET_ITEMS) begin
        if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 14));
        if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 63) == 0) wait_until_drained();
      end
      if ($urandom_range(0, 99) < insert_pct)
        send_item(ssq_pkg::MODE_INSERT, pick_priority(), ssq_pkg::TAG_W'($urandom));
      else
        send_item(ssq_pkg::MODE_POP, ssq_pkg::PRIO_W'($urandom),
                  ssq_pkg::TAG_W'($urandom));
    end
  endtask

  // Compare every result against the oldest prediction; the block cannot be stalled.
  always @(posedge clk) begin
    qresult_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing outstanding, status %0h id %0h",
                 $time, status, out_id);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)     report_mismatch("status", want.status, status);
        if (out_id !== want.id)         report_mismatch("out_id", want.id, out_id);
        if (out_priority !== want.prio) report_mismatch("out_priority", want.prio,
                                                        out_priority);
        if (out_tag !== want.tag)       report_mismatch("out_tag", want.tag, out_tag);
        if (occupancy !== want.occ)     report_mismatch("occupancy", want.occ, occupancy);
      end
    end
  end

  // Count cycles where neither side moves anything; give up past the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    mode         = ssq_pkg::MODE_INSERT;
    priority_req = '0;
    tag          = '0;
    error_count  = 0;
    shadow_count = 0;
    shadow_id    = ssq_pkg::ID_W'(1);
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_pop_on_empty();
    test_fill_to_full();
    test_pop_order();
    wait_until_drained();
    test_insert_pop_pairs();
    wait_until_drained();
    test_random_traffic();

    // Let the last results land, then watch a few more cycles for strays.
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssq_pkg.sv
src/ssq_ctrl.sv
src/ssq_dp.sv
src/stable_sorted_priority_queue.sv
dv/testbench.sv
